// ----- hdl/vbm_pkg.sv -----
// Package for the voice block mixer with peaks.
// Holds the command codes, the stream field layout, the queue entry type and the
// back-end state type. It depends on nothing else.
package vbm_pkg;

   // Command codes carried in req_tuser.
   localparam logic CMD_MIX = 1'b0;
   localparam logic CMD_END = 1'b1;

   // Request beat layout in req_tdata, from the lowest bit up.
   localparam int REQ_W       = 56;
   localparam int REQ_FRAME_L = 0;
   localparam int REQ_LEFT_L  = 4;
   localparam int REQ_RIGHT_L = 20;
   localparam int REQ_GAIN_L  = 36;
   localparam int REQ_LEN_B   = 52;
   localparam int REQ_REN_B   = 53;

   // Result beat layout in rsp_tdata, from the lowest bit up.
   localparam int RSP_W       = 72;
   localparam int RSP_WORD_L  = 0;
   localparam int RSP_SLOT_L  = 32;
   localparam int RSP_PEAKL_L = 37;
   localparam int RSP_PEAKR_L = 53;
   localparam int RSP_PAD_L   = 69;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // One classified item waiting for the back end.
   typedef struct packed {
      logic              is_end;
      logic [4:0]        slot;
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic [15:0]       gain;
      logic              do_left;
      logic              do_right;
   } vbm_entry_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      B_IDLE,
      B_READ,
      B_MULT,
      B_WRITE,
      B_EMIT_RD,
      B_EMIT_OUT
   } vbm_back_state_type;

endpackage

// ----- hdl/vbm_front.sv -----
// Front end of the voice block mixer: accepts request beats and classifies them.
// Depends on vbm_pkg; feeds vbm_queue.
module vbm_front import vbm_pkg::*; #(
   parameter int BLOCK_SIZE = 32
) (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,
   input  logic              req_tuser,
   input  logic              q_full,
   output logic              q_push,
   output vbm_entry_type     q_entry
);

   localparam int HALF = BLOCK_SIZE / 2;

   logic [3:0]  frame;
   logic [4:0]  slot;
   logic [31:0] frame_wide;
   logic [31:0] slot_wide;
   logic        in_range;
   logic        do_left;
   logic        do_right;
   logic        is_end;

   // Decode the beat and work out which slots it touches.
   always_comb begin
      frame      = req_tdata[REQ_FRAME_L +: 4];
      slot       = {frame, 1'b0};
      frame_wide = {28'b0, frame};
      slot_wide  = {27'b0, slot};
      is_end     = (req_tuser == CMD_END);
      in_range   = (frame_wide < HALF);
      do_left    = in_range && req_tdata[REQ_LEN_B];
      do_right   = in_range && req_tdata[REQ_REN_B] && ((slot_wide + 32'd1) < BLOCK_SIZE);
   end

   // A mix beat that changes no slot is dropped here.
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full && (is_end || do_left || do_right);

   always_comb begin
      q_entry.is_end       = is_end;
      q_entry.slot         = slot;
      q_entry.left_sample  = req_tdata[REQ_LEFT_L +: 16];
      q_entry.right_sample = req_tdata[REQ_RIGHT_L +: 16];
      q_entry.gain         = req_tdata[REQ_GAIN_L +: 16];
      q_entry.do_left      = do_left && !is_end;
      q_entry.do_right     = do_right && !is_end;
   end

endmodule

// ----- hdl/vbm_queue.sv -----
// Short queue between the front and back ends of the voice block mixer.
// Depends on vbm_pkg for the entry type and the depth.
module vbm_queue import vbm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  vbm_entry_type push_entry,
   output logic          full,
   output logic          q_valid,
   output vbm_entry_type q_entry,
   input  logic          pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   vbm_entry_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_entry = entry_ff[rd_ptr_ff];
   assign do_pop  = pop && q_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hdl/vbm_back.sv -----
// Back end of the voice block mixer: slot buffer, gain and mix datapath, block emission.
// Depends on vbm_pkg; takes entries from vbm_queue and drives the result stream.
module vbm_back import vbm_pkg::*; #(
   parameter int BLOCK_SIZE = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  vbm_entry_type    q_entry,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   localparam int SLOT_W     = $clog2(BLOCK_SIZE);
   localparam int PEAK_SLOTS = 2 * (BLOCK_SIZE / 2);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BLOCK_SIZE - 1);

   vbm_back_state_type state_ff, state_in;
   vbm_entry_type      cur_ff, cur_in;
   logic               chan_ff, chan_in;
   logic [SLOT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOT_W-1:0]  addr_ff;
   logic [SLOT_W-1:0]  rd_addr;
   logic [15:0]        peak_l_ff, peak_l_in;
   logic [15:0]        peak_r_ff, peak_r_in;

   // Slot memory with flip-flop valid bits standing in for the zero reset.
   logic signed [15:0] mem [BLOCK_SIZE];
   logic               valid_ff [BLOCK_SIZE];
   logic signed [15:0] rd_data_ff;
   logic               rd_valid_ff;
   logic               mem_we;
   logic signed [15:0] slot_value;

   // Datapath registers.
   logic signed [15:0] scaled_ff;
   logic [15:0]        fa_ff, fb_ff;
   logic [31:0]        prod_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_free;
   logic               emit_fire;

   logic [31:0]        slot_wide;
   logic [SLOT_W-1:0]  chan_addr;
   logic signed [15:0] sample;
   logic signed [32:0] scale_prod;
   logic signed [32:0] scale_q;
   logic signed [15:0] scale_sat;
   logic [15:0]        fa_nx, fb_nx;
   logic [16:0]        prod_hi;
   logic signed [20:0] sum2, q21, mix_raw;
   logic signed [15:0] mix_sat;
   logic [31:0]        cnt_wide;
   logic [15:0]        emit_abs;
   logic               in_peak;

   // Address of the slot for the current channel.
   always_comb begin
      slot_wide = {27'b0, cur_ff.slot} + {31'b0, chan_ff};
      chan_addr = slot_wide[SLOT_W-1:0];
      rd_addr   = (state_ff == B_READ) ? chan_addr : cnt_ff;
   end

   // Gain stage: product truncated toward zero, then saturated.
   always_comb begin
      sample     = chan_ff ? cur_ff.right_sample : cur_ff.left_sample;
      scale_prod = $signed(sample) * $signed({1'b0, cur_ff.gain});
      scale_q    = (scale_prod + (scale_prod[32] ? 33'sd255 : 33'sd0)) >>> 8;
      if (scale_q > 33'sd32767) begin
         scale_sat = 16'sh7FFF;
      end else if (scale_q < -33'sd32768) begin
         scale_sat = 16'sh8000;
      end else begin
         scale_sat = scale_q[15:0];
      end
   end

   // Offset both operands by half range for the mix product.
   always_comb begin
      slot_value = rd_valid_ff ? rd_data_ff : 16'sd0;
      fa_nx      = {~slot_value[15], slot_value[14:0]};
      fb_nx      = {~scaled_ff[15], scaled_ff[14:0]};
   end

   // Piecewise mix rule and saturation to 16 bits.
   always_comb begin
      prod_hi = prod_ff[31:15];
      sum2    = $signed({3'b0, ({1'b0, fa_ff} + {1'b0, fb_ff}), 1'b0});
      q21     = $signed({4'b0, prod_hi});
      if (!fa_ff[15] && !fb_ff[15]) begin
         mix_raw = q21 - 21'sd32768;
      end else begin
         mix_raw = sum2 - q21 - 21'sd98304;
      end
      if (mix_raw > 21'sd32767) begin
         mix_sat = 16'sh7FFF;
      end else if (mix_raw < -21'sd32768) begin
         mix_sat = 16'sh8000;
      end else begin
         mix_sat = mix_raw[15:0];
      end
   end

   // Emission word, running peaks and the result beat.
   always_comb begin
      cnt_wide  = {{(32 - SLOT_W){1'b0}}, cnt_ff};
      emit_abs  = slot_value[15] ? 16'(-slot_value) : slot_value;
      in_peak   = (cnt_wide < PEAK_SLOTS);
      peak_l_in = peak_l_ff;
      peak_r_in = peak_r_ff;
      if (in_peak && !cnt_ff[0] && (emit_abs > peak_l_ff)) begin
         peak_l_in = emit_abs;
      end
      if (in_peak && cnt_ff[0] && (emit_abs > peak_r_ff)) begin
         peak_r_in = emit_abs;
      end
      rsp_last_in = (cnt_ff == LAST_SLOT);
      rsp_data_in = '0;
      rsp_data_in[RSP_WORD_L +: 32] = {slot_value, 16'b0};
      rsp_data_in[RSP_SLOT_L +: 5]  = cnt_wide[4:0];
      if (rsp_last_in) begin
         rsp_data_in[RSP_PEAKL_L +: 16] = peak_l_in;
         rsp_data_in[RSP_PEAKR_L +: 16] = peak_r_in;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_fire = (state_ff == B_EMIT_OUT) && out_free;
   assign mem_we    = (state_ff == B_WRITE);

   // Sequencer: next state and control.
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      chan_in  = chan_ff;
      cnt_in   = cnt_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_entry;
               cnt_in = '0;
               if (q_entry.is_end) begin
                  state_in = B_EMIT_RD;
               end else begin
                  chan_in  = !q_entry.do_left;
                  state_in = B_READ;
               end
            end
         end
         B_READ: begin
            state_in = B_MULT;
         end
         B_MULT: begin
            state_in = B_WRITE;
         end
         B_WRITE: begin
            if (!chan_ff && cur_ff.do_right) begin
               chan_in  = 1'b1;
               state_in = B_READ;
            end else begin
               state_in = B_IDLE;
            end
         end
         B_EMIT_RD: begin
            state_in = B_EMIT_OUT;
         end
         B_EMIT_OUT: begin
            if (out_free) begin
               if (cnt_ff == LAST_SLOT) begin
                  state_in = B_IDLE;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = B_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         chan_ff   <= 1'b0;
         cnt_ff    <= '0;
         peak_l_ff <= '0;
         peak_r_ff <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         cnt_ff   <= cnt_in;
         if ((state_ff == B_IDLE) && q_valid && q_entry.is_end) begin
            peak_l_ff <= '0;
            peak_r_ff <= '0;
         end else if (emit_fire) begin
            peak_l_ff <= peak_l_in;
            peak_r_ff <= peak_r_in;
         end
      end
   end

   // Entry and datapath registers carry no reset.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (state_ff == B_READ) begin
         addr_ff   <= chan_addr;
         scaled_ff <= scale_sat;
      end
      if (state_ff == B_MULT) begin
         fa_ff   <= fa_nx;
         fb_ff   <= fb_nx;
         prod_ff <= fa_nx * fb_nx;
      end
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mix_sat;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // Valid bits: cleared by reset, set on a mix write, cleared as a slot is emitted.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BLOCK_SIZE; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (mem_we) begin
         valid_ff[addr_ff] <= 1'b1;
      end else if (emit_fire) begin
         valid_ff[cnt_ff] <= 1'b0;
      end
   end

   // Result register: takes a new beat whenever the old one is gone or taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- hdl/voice_block_mixer_with_peaks.sv -----
// A mix beat goes through the queue, then the back end runs the three-step read, multiply
// and write sequence once for each enabled channel, and the result lands in its slot.
// The back end handles one beat at a time and pops the next only when done. An end-of-block
// beat emits the slots in order, each read before it is sent, and stalls on a busy receiver.
// The front accepts while its two-entry queue has room. Reset clears the slot valid
// bits, so the buffer reads as zero without a clearing pass.
module voice_block_mixer_with_peaks import vbm_pkg::*; #(
   parameter int BLOCK_SIZE = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // frame_index[3:0], left_sample[19:4], right_sample[35:20], gain[51:36],
   // left_enable[52], right_enable[53], zero padding[55:54]
   input  logic [REQ_W-1:0] req_tdata,
   // command[0]
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // out_word[31:0], slot_index[36:32], peak_left[52:37], peak_right[68:53],
   // zero padding[71:69]
   output logic [RSP_W-1:0] rsp_tdata,
   // last
   output logic             rsp_tlast
);

   logic          q_full;
   logic          q_push;
   vbm_entry_type push_entry;
   logic          q_valid;
   vbm_entry_type q_entry;
   logic          q_pop;

   vbm_front #(.BLOCK_SIZE(BLOCK_SIZE)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   vbm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .pop        (q_pop)
   );

   vbm_back #(.BLOCK_SIZE(BLOCK_SIZE)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- hdl/vbm_checker.sv -----
// Port-level checks for the voice block mixer, with the bind that attaches them.
// Depends on vbm_pkg for the result beat layout.
module vbm_checker import vbm_pkg::*; #(
   parameter int BLOCK_SIZE = 32
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   localparam logic [4:0] LAST_INDEX = 5'(BLOCK_SIZE - 1);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // Peaks are only reported on the final word.
   a_peaks_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[RSP_PAD_L-1:RSP_PEAKL_L] == '0)
      else $error("peak fields set on a word that is not last");

   // Slot values are shifted up, so the low half of the word is zero.
   a_word_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_WORD_L +: 16] == 16'b0)
      else $error("low half of the output word is not zero");

   // The final word belongs to the last slot of the block.
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[RSP_SLOT_L +: 5] == LAST_INDEX)
      else $error("last word carries the wrong slot index");

endmodule

bind voice_block_mixer_with_peaks vbm_checker #(.BLOCK_SIZE(BLOCK_SIZE)) u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- bench/tb_top.sv -----
// Self-checking bench for voice_block_mixer_with_peaks: random and directed mix and
// end-of-block beats, with the expected slot words predicted by a scoreboard class.
// Depends on vbm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
   import vbm_pkg::*;

   localparam int SLOTS = 32;
   localparam int RUN_LIMIT_NS = 5_000_000;

   // One expected result beat, split into its fields.
   typedef struct {
      logic [31:0] word;
      logic [4:0]  slot;
      logic [15:0] peak_l;
      logic [15:0] peak_r;
      logic        last;
   } slot_word_type;

   // Keeps a private copy of the stereo buffer and the words it will emit.
   class mix_scoreboard;
      logic signed [15:0] slot_value [SLOTS];
      slot_word_type      words_due [$];
      int                 fail_count;

      function new();
         foreach (slot_value[i]) slot_value[i] = '0;
         fail_count = 0;
      endfunction

      function logic signed [15:0] clamp16(longint v);
         if (v > 32767) return 16'sd32767;
         if (v < -32768) return -16'sd32768;
         return v[15:0];
      endfunction

      // Q8.8 gain, truncated toward zero, then saturated.
      function logic signed [15:0] gain_scale(logic signed [15:0] s, logic [15:0] g);
         longint p;
         longint q;
         p = longint'(s) * longint'(g);
         q = (p >= 0) ? p / 256 : -((-p) / 256);
         return clamp16(q);
      endfunction

      // Piecewise multiplicative blend on offset-binary values.
      function logic signed [15:0] blend_slot(logic signed [15:0] a, logic signed [15:0] b);
         longint fa;
         longint fb;
         longint fz;
         fa = longint'(a) + 32768;
         fb = longint'(b) + 32768;
         if (fa < 32768 && fb < 32768)
            fz = (fa * fb) / 32768;
         else
            fz = 2 * (fa + fb) - (fa * fb) / 32768 - 65536;
         return clamp16(fz - 32768);
      endfunction

      // Called once for every request beat that the block accepts.
      function void note_beat(logic cmd, logic [REQ_W-1:0] d);
         int            slot;
         int            pk_l;
         int            pk_r;
         int            mag;
         slot_word_type w;
         if (cmd == CMD_MIX) begin
            slot = 2 * int'(d[REQ_FRAME_L +: 4]);
            if (d[REQ_LEN_B])
               slot_value[slot] = blend_slot(slot_value[slot],
                  gain_scale(d[REQ_LEFT_L +: 16], d[REQ_GAIN_L +: 16]));
            if (d[REQ_REN_B])
               slot_value[slot+1] = blend_slot(slot_value[slot+1],
                  gain_scale(d[REQ_RIGHT_L +: 16], d[REQ_GAIN_L +: 16]));
         end else begin
            pk_l = 0;
            pk_r = 0;
            for (int i = 0; i < SLOTS; i++) begin
               mag = (slot_value[i] < 0) ? -int'(slot_value[i]) : int'(slot_value[i]);
               if (i % 2 == 0 && mag > pk_l) pk_l = mag;
               if (i % 2 == 1 && mag > pk_r) pk_r = mag;
            end
            for (int i = 0; i < SLOTS; i++) begin
               w.word   = {slot_value[i], 16'h0000};
               w.slot   = i[4:0];
               w.last   = (i == SLOTS - 1);
               w.peak_l = w.last ? pk_l[15:0] : 16'h0000;
               w.peak_r = w.last ? pk_r[15:0] : 16'h0000;
               words_due.push_back(w);
               slot_value[i] = '0;
            end
         end
      endfunction

      task report(string msg);
         $display("%0t ns mismatch: %s", $time, msg);
         fail_count++;
      endtask

      // Compares one accepted result beat with the oldest word still due.
      task check_word(logic [RSP_W-1:0] d, logic tlast);
         slot_word_type w;
         if (words_due.size() == 0) begin
            report($sformatf("unexpected beat, data %h", d));
            return;
         end
         w = words_due.pop_front();
         if (d[RSP_WORD_L +: 32] !== w.word)
            report($sformatf("slot %0d word %h, want %h", w.slot, d[RSP_WORD_L +: 32], w.word));
         if (d[RSP_SLOT_L +: 5] !== w.slot)
            report($sformatf("slot index %0d, want %0d", d[RSP_SLOT_L +: 5], w.slot));
         if (d[RSP_PEAKL_L +: 16] !== w.peak_l)
            report($sformatf("slot %0d left peak %0d, want %0d", w.slot,
                             d[RSP_PEAKL_L +: 16], w.peak_l));
         if (d[RSP_PEAKR_L +: 16] !== w.peak_r)
            report($sformatf("slot %0d right peak %0d, want %0d", w.slot,
                             d[RSP_PEAKR_L +: 16], w.peak_r));
         if (tlast !== w.last)
            report($sformatf("slot %0d tlast %b, want %b", w.slot, tlast, w.last));
      endtask

      function int words_pending();
         return words_due.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tuser = CMD_MIX;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   logic          hold_off = 1'b0;
   bit            pressure_go = 1'b0;
   mix_scoreboard sb = new();

   voice_block_mixer_with_peaks #(.BLOCK_SIZE(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, plus the long hold-off when asked.
   always @(posedge clock) begin
      if (hold_off)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata, rsp_tlast);
   end

   // Long receiver hold-off, so that the block backs up and stalls its input.
   initial begin
      wait (pressure_go);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Run limit.
   initial begin
      #(RUN_LIMIT_NS);
      $display("** voice_block_mixer_with_peaks: FAILED **");
      $finish;
   end

   function automatic logic [REQ_W-1:0] mix_fields(logic [3:0] frame, logic [15:0] ls,
      logic [15:0] rs, logic [15:0] g, logic len, logic ren);
      logic [REQ_W-1:0] d;
      d = '0;
      d[REQ_FRAME_L +: 4]  = frame;
      d[REQ_LEFT_L +: 16]  = ls;
      d[REQ_RIGHT_L +: 16] = rs;
      d[REQ_GAIN_L +: 16]  = g;
      d[REQ_LEN_B]         = len;
      d[REQ_REN_B]         = ren;
      return d;
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(3))
         0: return 16'($urandom_range(300) - 150);
         1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(3))
         0: return 16'($urandom_range(512));
         1: return 16'hFF00 + 16'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   // Offers one beat, idling first at the current rate, and waits for acceptance.
   task send_beat(logic cmd, logic [REQ_W-1:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_beat(cmd, d);
   endtask

   task send_random_mix();
      send_beat(CMD_MIX, mix_fields(4'($urandom), pick_sample(), pick_sample(), pick_gain(),
                                    1'($urandom), 1'($urandom)));
   endtask

   // Unused fields of an end beat carry random values.
   task send_block_end();
      send_beat(CMD_END, mix_fields(4'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 1'($urandom), 1'($urandom)));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty block, saturating gains, both corners of the blend,
      // truncation toward zero, single and no enables, outer frames.
      send_block_end();
      send_beat(CMD_MIX, mix_fields(4'd0, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1));
      send_beat(CMD_MIX, mix_fields(4'd0, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1));
      send_beat(CMD_MIX, mix_fields(4'd15, 16'h7FFF, 16'hFFFF, 16'h0100, 1'b1, 1'b0));
      send_beat(CMD_MIX, mix_fields(4'd15, 16'h7FFF, 16'h8000, 16'h0001, 1'b0, 1'b1));
      send_beat(CMD_MIX, mix_fields(4'd7, 16'h1234, 16'h4321, 16'h0200, 1'b0, 1'b0));
      send_beat(CMD_MIX, mix_fields(4'd3, 16'hFF01, 16'h00FF, 16'h0001, 1'b1, 1'b1));
      send_beat(CMD_MIX, mix_fields(4'd8, 16'h5555, 16'hAAAA, 16'h5555, 1'b1, 1'b1));
      send_beat(CMD_MIX, mix_fields(4'd9, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b1));
      send_beat(CMD_MIX, mix_fields(4'd1, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b1));
      send_beat(CMD_MIX, mix_fields(4'd2, 16'h8000, 16'h8000, 16'h0000, 1'b1, 1'b1));
      send_block_end();
      send_beat(CMD_MIX, mix_fields(4'd5, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1));
      send_beat(CMD_MIX, mix_fields(4'd5, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1));
      send_beat(CMD_MIX, mix_fields(4'd10, 16'hC000, 16'h4000, 16'h0180, 1'b1, 1'b1));
      send_beat(CMD_MIX, mix_fields(4'd10, 16'hC000, 16'h4000, 16'h0180, 1'b1, 1'b1));
      send_block_end();

      // Random phases: no idling, sender idle, receiver stalling, both.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 61 : (ph == 3) ? 30 : 0;
         recv_stall_pct = (ph == 2) ? 61 : (ph == 3) ? 30 : 0;
         if (ph == 0) begin
            pressure_go = 1'b1;
            send_block_end();
         end
         for (int n = 0; n < 38; n++) begin
            if ($urandom_range(99) < 8)
               send_block_end();
            else
               send_random_mix();
         end
      end
      send_block_end();
      req_tvalid <= 1'b0;

      // Drain: every due word, then a further wait for any stray beat.
      while (sb.words_pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.fail_count == 0)
         $display("** voice_block_mixer_with_peaks: PASSED **");
      else
         $display("** voice_block_mixer_with_peaks: FAILED **");
      $finish;
   end

endmodule

// ----- voice_block_mixer_with_peaks.f -----
hdl/vbm_pkg.sv
hdl/vbm_front.sv
hdl/vbm_queue.sv
hdl/vbm_back.sv
hdl/voice_block_mixer_with_peaks.sv
hdl/vbm_checker.sv
bench/tb_top.sv
